// ----- rtl/sis_pkg.sv -----
package sis_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_READ_ASC  = 2'd1;
  localparam logic [1:0] OP_READ_DESC = 2'd2;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_t;

  typedef struct packed {
    logic             insert;
    logic             load;
    logic [1:0]       status;
    logic             last;
    logic [IDX_W-1:0] rd_idx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
  } sts_t;

endpackage

// ----- rtl/sis_ctrl.sv -----
module sis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  output logic                out_valid,
  input  logic                out_stall,
  input  sis_pkg::sts_t       sts,
  output sis_pkg::cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                      state_r, state_nxt;
  logic [sis_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                      desc_r, desc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_free;
  logic                      acc;
  logic [sis_pkg::CNT_W-1:0] k_ext;
  logic [sis_pkg::CNT_W-1:0] k_inc;
  logic [sis_pkg::CNT_W-1:0] rev_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign k_ext     = {{(sis_pkg::CNT_W - sis_pkg::IDX_W){1'b0}}, k_r};
  assign k_inc     = k_ext + sis_pkg::CNT_W'(1);
  assign rev_idx   = sts.count - k_inc;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    desc_nxt  = desc_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_op)
            sis_pkg::OP_INSERT: begin
              cmd.load = 1'b1;
              cmd.last = 1'b1;
              if (sts.full) begin
                cmd.status = sis_pkg::ST_FULL;
              end else begin
                cmd.insert = 1'b1;
                cmd.status = sis_pkg::ST_ACCEPTED;
              end
            end
            sis_pkg::OP_READ_ASC, sis_pkg::OP_READ_DESC: begin
              if (sts.count == '0) begin
                cmd.load   = 1'b1;
                cmd.last   = 1'b1;
                cmd.status = sis_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_READ;
                k_nxt     = '0;
                desc_nxt  = (in_op == sis_pkg::OP_READ_DESC);
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          cmd.status = sis_pkg::ST_DATA;
          cmd.rd_idx = desc_r ? rev_idx[sis_pkg::IDX_W-1:0] : k_r;
          cmd.last   = (k_inc == sts.count);
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + sis_pkg::IDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      desc_r      <= desc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/sis_dp.sv -----
module sis_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sis_pkg::cmd_t      cmd,
  input  logic signed [31:0] value,
  output sis_pkg::sts_t      sts,
  output sis_pkg::out_t      out_data
);

  logic signed [31:0]        cells_r [sis_pkg::CAPACITY];
  logic [sis_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [sis_pkg::CAPACITY-1:0] ins;
  sis_pkg::out_t             out_r;

  assign sts.count = count_r;
  assign sts.full  = (count_r == sis_pkg::CNT_W'(sis_pkg::CAPACITY));
  assign out_data  = out_r;
  assign count_nxt = cmd.insert ? count_r + sis_pkg::CNT_W'(1) : count_r;

  // ins[i]: the new value lands at or before cell i
  always_comb begin
    for (int i = 0; i < sis_pkg::CAPACITY; i++) begin
      ins[i] = (sis_pkg::CNT_W'(i) >= count_r) || (value < cells_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (ins[0]) begin
        cells_r[0] <= value;
      end
      for (int i = 1; i < sis_pkg::CAPACITY; i++) begin
        if (ins[i]) begin
          cells_r[i] <= ins[i-1] ? cells_r[i-1] : value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.data   <= (cmd.status == sis_pkg::ST_DATA) ? cells_r[cmd.rd_idx] : 32'sd0;
      out_r.status <= cmd.status;
      out_r.last   <= cmd.last;
    end
  end

endmodule

// ----- rtl/sorted_insert_store.sv -----
// Sorted store of up to 32 signed 32-bit values held in a chain of registers.
// On an insert, every cell compares itself against the new value
// and the chain shifts up past the insertion point; one status result follows
// (accepted, or dropped when full). A read is accepted first and then streams
// one stored entry per cycle while the receiver does not stall, ascending or
// descending, the last one marked; an empty store gives a single
// empty-status result. Items are handled one at a time; op code 3 is ignored.
// The result register lets the next item enter in the same cycle that a
// waiting result is taken.
module sorted_insert_store (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sis_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sis_pkg::out_t out_data
);

  sis_pkg::cmd_t cmd;
  sis_pkg::sts_t sts;

  sis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sis_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .value    (in_data.value),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- test/sorted_insert_store_tb.sv -----
`timescale 1ns / 100ps

module sorted_insert_store_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 370;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  sis_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sis_pkg::out_t out_data;

  sis_pkg::in_t       pending_items[$];
  sis_pkg::out_t      expected_results[$];
  logic signed [31:0] sorted_shadow[$];

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sorted_insert_store uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  task automatic push_result(input logic signed [31:0] data, input logic [1:0] status,
                             input logic last);
    sis_pkg::out_t res;
    res.data   = data;
    res.status = status;
    res.last   = last;
    expected_results.push_back(res);
  endtask

  // sorted insert after equal entries; reads stream the shadow list
  task automatic apply_item(input sis_pkg::in_t item);
    int pos;
    int n;
    pos = 0;
    n = sorted_shadow.size();
    case (item.op)
      sis_pkg::OP_INSERT: begin
        if (n >= sis_pkg::CAPACITY) begin
          push_result('0, sis_pkg::ST_FULL, 1'b1);
        end else begin
          while (pos < n && !(item.value < sorted_shadow[pos])) pos++;
          sorted_shadow.insert(pos, item.value);
          push_result('0, sis_pkg::ST_ACCEPTED, 1'b1);
        end
      end
      sis_pkg::OP_READ_ASC, sis_pkg::OP_READ_DESC: begin
        if (n == 0) begin
          push_result('0, sis_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < n; k++)
            push_result((item.op == sis_pkg::OP_READ_ASC) ? sorted_shadow[k]
                                                          : sorted_shadow[n-1-k],
                        sis_pkg::ST_DATA, k == n - 1);
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(16)) - 8;
      4: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        if ($urandom_range(1) == 0) return 32'sh8000_0000 + int'($urandom_range(3));
        else return 32'sh7fff_ffff - int'($urandom_range(3));
      end
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic signed [31:0] value);
    sis_pkg::in_t item;
    item.op    = op;
    item.value = value;
    pending_items.push_back(item);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        apply_item(in_data);
        void'(pending_items.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall density changes at random from pattern to pattern, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
          pattern_left = $urandom_range(200, 10);
        end
        pattern_left--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    sis_pkg::out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected transaction: data %0d status %0d last %0d",
                   out_data.data, out_data.status, out_data.last);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.data !== exp_res.data || out_data.status !== exp_res.status ||
            out_data.last !== exp_res.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch (data/status/last): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     exp_res.data, exp_res.status, exp_res.last,
                     out_data.data, out_data.status, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int counted;
    int r;
    logic [1:0] op;
    counted = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_item(sis_pkg::OP_READ_ASC, 32'sd5);
    queue_item(sis_pkg::OP_READ_DESC, -32'sd5);
    queue_item(OP_UNUSED, 32'sh7fff_ffff);
    queue_item(sis_pkg::OP_INSERT, 32'sd0);
    queue_item(sis_pkg::OP_INSERT, 32'sh8000_0000);
    queue_item(sis_pkg::OP_INSERT, 32'sh7fff_ffff);
    queue_item(sis_pkg::OP_INSERT, -32'sd1);
    queue_item(sis_pkg::OP_INSERT, 32'sd1);
    queue_item(sis_pkg::OP_READ_ASC, 32'sd0);
    queue_item(sis_pkg::OP_INSERT, 32'sd0);
    queue_item(sis_pkg::OP_INSERT, 32'sh7fff_ffff);
    queue_item(sis_pkg::OP_INSERT, 32'sh8000_0000);
    queue_item(sis_pkg::OP_INSERT, 32'sh5555_aaaa);
    queue_item(OP_UNUSED, 32'sh8000_0000);
    queue_item(sis_pkg::OP_READ_ASC, 32'sh7fff_ffff);
    queue_item(sis_pkg::OP_READ_DESC, 32'sh8000_0000);
    wait_idle();

    // long receiver hold while the sender keeps offering
    hold_armed = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 6) op = OP_UNUSED;
      else if (r < 62) op = sis_pkg::OP_INSERT;
      else if (r < 81) op = sis_pkg::OP_READ_ASC;
      else op = sis_pkg::OP_READ_DESC;
      queue_item(op, pick_value());
      counted++;
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
